[design/cdoc_pkg.sv]
// Package for the CIGAR deletion overlap caller.
// Holds widths, op codes, register indexes, reset values and shared types.
// No dependencies.
package cdoc_pkg;

   // Field widths
   localparam int unsigned OPC_W      = 4;
   localparam int unsigned LEN_W      = 28;
   localparam int unsigned POS_W      = 31;
   localparam int unsigned MAPQ_W     = 8;
   localparam int unsigned FRAC_W     = 17;
   localparam int unsigned OFS_W      = 32;
   // read_start + offset + length stays below 2^33
   localparam int unsigned COORD_W    = 33;
   // larger interval length stays at or below 2^31
   localparam int unsigned BIG_W      = 32;
   localparam int unsigned REM_W      = BIG_W + 1;
   localparam int unsigned TLEN_W     = POS_W + 2;
   localparam int unsigned SHARED_W   = COORD_W + 2;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 31;

   // Divider: one quotient bit per step
   localparam int unsigned FRAC_STEPS = FRAC_W;
   localparam int unsigned STEP_W     = $clog2(FRAC_STEPS);
   localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);

   // Defaults of the top-level parameters
   localparam int unsigned MIN_DEL_LEN_DEF = 20;
   localparam int unsigned FIFO_DEPTH_DEF  = 4;

   // CIGAR op codes that move along the reference
   localparam logic [OPC_W-1:0] OP_M  = 4'd0;
   localparam logic [OPC_W-1:0] OP_D  = 4'd2;
   localparam logic [OPC_W-1:0] OP_EQ = 4'd7;
   localparam logic [OPC_W-1:0] OP_X  = 4'd8;

   // Register reset values
   localparam logic [MAPQ_W-1:0] MIN_MAPQ_RST    = 8'd10;
   localparam logic [FRAC_W-1:0] MIN_OVERLAP_RST = 17'd32768;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_MAPQ    = 2'd0,
      CSR_MIN_OVERLAP = 2'd1,
      CSR_SV_START    = 2'd2,
      CSR_SV_END      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [MAPQ_W-1:0] min_map_quality;
      logic [FRAC_W-1:0] min_overlap;
      logic [POS_W-1:0]  sv_start;
      logic [POS_W-1:0]  sv_end;
   } cdoc_cfg_type;

   // Deletion candidate handed from front to back, one-based full-width interval
   typedef struct packed {
      logic [COORD_W-1:0] del_start;
      logic [COORD_W-1:0] del_end;
      logic [LEN_W-1:0]   del_length;
      logic               minus_strand;
   } cdoc_cand_type;

   typedef struct packed {
      logic [POS_W-1:0]  del_start;
      logic [POS_W-1:0]  del_end;
      logic [LEN_W-1:0]  del_length;
      logic [FRAC_W-1:0] overlap_fraction;
      logic              minus_strand;
   } cdoc_result_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PREP,
      BK_DIV,
      BK_DONE
   } cdoc_back_state_type;

endpackage

[design/cdoc_front.sv]
// Front end of the deletion caller: read filter, reference offset tracking,
// deletion candidate extraction. Depends on cdoc_pkg.
module cdoc_front import cdoc_pkg::*; #(
   parameter int unsigned MIN_DEL_LEN = MIN_DEL_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                first_of_read,
   input  logic [OPC_W-1:0]    op_code,
   input  logic [LEN_W-1:0]    op_length,
   input  logic [POS_W-1:0]    read_start,
   input  logic [MAPQ_W-1:0]   map_quality,
   input  logic                is_duplicate,
   input  logic                failed_qc,
   input  logic                is_unmapped,
   input  logic                reverse_strand,
   input  logic [MAPQ_W-1:0]   min_map_quality,
   input  logic                queue_full,
   output logic                cand_push,
   output cdoc_cand_type       cand
);

   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_DEL_LEN);

   logic [OFS_W-1:0] ref_offset_ff;
   logic [OFS_W-1:0] ref_offset_in;
   logic [OFS_W-1:0] offset_base;
   logic             accept;
   logic             dropped;
   logic             advance;
   logic             long_del;

   assign accept      = push & ~queue_full;
   assign dropped     = (map_quality < min_map_quality) | is_duplicate | failed_qc | is_unmapped;
   assign offset_base = first_of_read ? '0 : ref_offset_ff;
   assign long_del    = (op_code == OP_D) && (op_length >= MIN_LEN);

   // Classify ops that consume reference bases
   always_comb begin
      case (op_code) inside
         OP_M, OP_D, OP_EQ, OP_X: advance = 1'b1;
         default:                 advance = 1'b0;
      endcase
   end

   // Advance the offset; a new read clears it even when the read is dropped
   always_comb begin
      ref_offset_in = ref_offset_ff;
      if (accept) begin
         if (!dropped && advance) begin
            ref_offset_in = offset_base + OFS_W'(op_length);
         end else begin
            ref_offset_in = offset_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_offset_ff <= '0;
      end else begin
         ref_offset_ff <= ref_offset_in;
      end
   end

   // Build the one-based deletion interval
   assign cand.del_start    = COORD_W'(read_start) + COORD_W'(offset_base) + COORD_W'(1);
   assign cand.del_end      = COORD_W'(read_start) + COORD_W'(offset_base) + COORD_W'(op_length);
   assign cand.del_length   = op_length;
   assign cand.minus_strand = reverse_strand;
   assign cand_push         = accept & ~dropped & long_del;

endmodule

[design/cdoc_fifo.sv]
// Candidate queue between front and back ends.
// Register-based FIFO; depends on cdoc_pkg for the entry type.
module cdoc_fifo import cdoc_pkg::*; #(
   parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cdoc_cand_type  push_data,
   output logic           full,
   input  logic           pop,
   output cdoc_cand_type  pop_data,
   output logic           empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cdoc_cand_type     entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/cdoc_back.sv]
// Back end of the deletion caller: overlap with the target interval,
// bit-serial reciprocal overlap divide, threshold and result register.
// Depends on cdoc_pkg.
module cdoc_back import cdoc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cdoc_cfg_type     cfg,
   input  logic             queue_empty,
   input  cdoc_cand_type    queue_data,
   output logic             queue_pop,
   output logic             rsp_empty,
   output cdoc_result_type  rsp_data,
   input  logic             rsp_pop
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_STEPS - 1);

   cdoc_back_state_type        state_ff;
   cdoc_back_state_type        state_in;
   cdoc_cand_type              cand_ff;
   cdoc_cand_type              cand_in;
   logic [COORD_W-1:0]         lo_ff;
   logic [COORD_W-1:0]         lo_in;
   logic [COORD_W-1:0]         hi_ff;
   logic [COORD_W-1:0]         hi_in;
   logic signed [TLEN_W-1:0]   tlen_ff;
   logic signed [TLEN_W-1:0]   tlen_in;
   logic [BIG_W-1:0]           big_ff;
   logic [BIG_W-1:0]           big_in;
   logic [REM_W-1:0]           rem_ff;
   logic [REM_W-1:0]           rem_in;
   logic [FRAC_W-1:0]          quo_ff;
   logic [FRAC_W-1:0]          quo_in;
   logic [STEP_W-1:0]          step_ff;
   logic [STEP_W-1:0]          step_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   cdoc_result_type            rsp_data_ff;
   cdoc_result_type            rsp_data_in;

   logic [COORD_W-1:0]         ts_ext;
   logic [COORD_W-1:0]         te_ext;
   logic signed [SHARED_W-1:0] shared;
   logic                       shared_pos;
   logic [REM_W-1:0]           shifted;
   logic                       ge;
   logic                       hit;
   logic                       out_free;
   logic                       load_rsp;
   logic                       last_step;

   assign ts_ext     = COORD_W'(cfg.sv_start);
   assign te_ext     = COORD_W'(cfg.sv_end);
   assign shared     = $signed({2'b00, hi_ff}) - $signed({2'b00, lo_ff})
                       + SHARED_W'(signed'(1));
   assign shared_pos = !shared[SHARED_W-1] && (shared != '0);
   assign shifted    = (step_ff == '0) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign ge         = shifted >= {1'b0, big_ff};
   assign last_step  = (step_ff == LAST_STEP);
   assign hit        = quo_ff >= cfg.min_overlap;
   assign out_free   = !rsp_valid_ff || rsp_pop;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!queue_empty) state_in = BK_PREP;
         BK_PREP: state_in = shared_pos ? BK_DIV : BK_IDLE;
         BK_DIV:  if (last_step) state_in = BK_DONE;
         BK_DONE: if (!hit || out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      queue_pop = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         BK_IDLE: queue_pop = !queue_empty;
         BK_PREP: ;
         BK_DIV:  ;
         BK_DONE: load_rsp = hit && out_free;
         default: ;
      endcase
   end

   // Datapath: clip to the target, pick the larger length, divide one bit a step
   always_comb begin
      cand_in     = cand_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      tlen_in     = tlen_ff;
      big_in      = big_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      rsp_data_in = rsp_data_ff;
      if (queue_pop) begin
         cand_in = queue_data;
         lo_in   = (queue_data.del_start > ts_ext) ? queue_data.del_start : ts_ext;
         hi_in   = (queue_data.del_end < te_ext) ? queue_data.del_end : te_ext;
         tlen_in = $signed({2'b00, cfg.sv_end}) - $signed({2'b00, cfg.sv_start})
                   + TLEN_W'(signed'(1));
      end
      if (state_ff == BK_PREP) begin
         big_in  = (tlen_ff[BIG_W-1:0] > BIG_W'(cand_ff.del_length)) ?
                   tlen_ff[BIG_W-1:0] : BIG_W'(cand_ff.del_length);
         rem_in  = shared[REM_W-1:0];
         quo_in  = '0;
         step_in = '0;
      end
      if (state_ff == BK_DIV) begin
         rem_in  = ge ? shifted - {1'b0, big_ff} : shifted;
         quo_in  = {quo_ff[FRAC_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
      end
      if (load_rsp) begin
         rsp_data_in.del_start        = cand_ff.del_start[POS_W-1:0];
         rsp_data_in.del_end          = cand_ff.del_end[POS_W-1:0];
         rsp_data_in.del_length       = cand_ff.del_length;
         rsp_data_in.overlap_fraction = quo_ff;
         rsp_data_in.minus_strand     = cand_ff.minus_strand;
      end
   end

   // Hold the result until it is popped
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      tlen_ff     <= tlen_in;
      big_ff      <= big_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Partial remainder stays below the divisor once a step has run
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && step_ff != '0) |-> (rem_ff < {1'b0, big_ff}))
      else $error("divider remainder out of range");

   // Reciprocal overlap never exceeds one
   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DONE) |-> (quo_ff <= Q16_ONE))
      else $error("overlap fraction above one");

   // A new result appears only from the threshold check
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff == BK_DONE && hit))
      else $error("result loaded outside the threshold check");

endmodule

[design/cigar_deletion_overlap_caller_top.sv]
// CIGAR deletion caller, top level: configuration registers, front end,
// candidate queue and back end. Depends on cdoc_pkg, cdoc_front, cdoc_fifo, cdoc_back.
//
// Takes one CIGAR operation per clock on the push/full side as long as the
// candidate queue has room; every operation, filtered or not, passes through
// the front end, where the per-read reference offset is accumulated. Each
// deletion of at least MIN_DEL_LEN bases from an accepted read becomes a
// candidate in a FIFO_DEPTH-entry queue. The back end takes a candidate that
// overlaps the target interval through queue pop and clip, shared and larger
// length, the one-bit-per-cycle restoring divider and the threshold check,
// and drops one that misses it after the shared and larger length step. full
// rises once FIFO_DEPTH candidates wait, that is when long deletions arrive
// faster than the back end retires them or while a passing deletion holds
// the back end at the threshold check until the result register is popped.
// There is no clearing pass after reset. Write the csr_ registers only while
// the block is idle.
module cigar_deletion_overlap_caller_top import cdoc_pkg::*; #(
   parameter int unsigned MIN_DEL_LEN = MIN_DEL_LEN_DEF,
   parameter int unsigned FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_first_of_read,
   input  logic [OPC_W-1:0]      req_op_code,
   input  logic [LEN_W-1:0]      req_op_length,
   input  logic [POS_W-1:0]      req_read_start,
   input  logic [MAPQ_W-1:0]     req_map_quality,
   input  logic                  req_is_duplicate,
   input  logic                  req_failed_qc,
   input  logic                  req_is_unmapped,
   input  logic                  req_reverse_strand,
   output logic                  empty,
   input  logic                  pop,
   output logic [POS_W-1:0]      rsp_del_start,
   output logic [POS_W-1:0]      rsp_del_end,
   output logic [LEN_W-1:0]      rsp_del_length,
   output logic [FRAC_W-1:0]     rsp_overlap_fraction,
   output logic                  rsp_minus_strand,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cdoc_cfg_type     cfg_ff;
   cdoc_cfg_type     cfg_in;
   logic             cand_push;
   cdoc_cand_type    cand;
   logic             queue_full;
   logic             queue_empty;
   logic             queue_pop;
   cdoc_cand_type    queue_data;
   cdoc_result_type  rsp_data;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_MIN_MAPQ:    cfg_in.min_map_quality = csr_wdata[MAPQ_W-1:0];
            CSR_MIN_OVERLAP: cfg_in.min_overlap     = csr_wdata[FRAC_W-1:0];
            CSR_SV_START:    cfg_in.sv_start        = csr_wdata[POS_W-1:0];
            CSR_SV_END:      cfg_in.sv_end          = csr_wdata[POS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_map_quality <= MIN_MAPQ_RST;
         cfg_ff.min_overlap     <= MIN_OVERLAP_RST;
         cfg_ff.sv_start        <= '0;
         cfg_ff.sv_end          <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign full = queue_full;

   cdoc_front #(
      .MIN_DEL_LEN (MIN_DEL_LEN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .first_of_read   (req_first_of_read),
      .op_code         (req_op_code),
      .op_length       (req_op_length),
      .read_start      (req_read_start),
      .map_quality     (req_map_quality),
      .is_duplicate    (req_is_duplicate),
      .failed_qc       (req_failed_qc),
      .is_unmapped     (req_is_unmapped),
      .reverse_strand  (req_reverse_strand),
      .min_map_quality (cfg_ff.min_map_quality),
      .queue_full      (queue_full),
      .cand_push       (cand_push),
      .cand            (cand)
   );

   cdoc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cand_push),
      .push_data (cand),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .empty     (queue_empty)
   );

   cdoc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .queue_pop   (queue_pop),
      .rsp_empty   (empty),
      .rsp_data    (rsp_data),
      .rsp_pop     (pop)
   );

   assign rsp_del_start        = rsp_data.del_start;
   assign rsp_del_end          = rsp_data.del_end;
   assign rsp_del_length       = rsp_data.del_length;
   assign rsp_overlap_fraction = rsp_data.overlap_fraction;
   assign rsp_minus_strand     = rsp_data.minus_strand;

endmodule
